/* rtl/hsc_pkg.sv */
// Package for the counted heap sort block: sizes, sequencer states and the
// result beat record. It depends on nothing else.
`default_nettype none

package hsc_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned STEP_W       = 12;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CHILD_W      = IDX_W + 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_SIFT_HELD,
    ST_LOOP,
    ST_C1,
    ST_C2,
    ST_DRAIN,
    ST_SW_RD1,
    ST_SW_WR,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic                     load;
    logic                     last;
    logic signed [VAL_W-1:0]  value;
    logic [STEP_W-1:0]        count;
  } res_t;

endpackage

`default_nettype wire

/* rtl/hsc_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with the
// read data registered. It depends on nothing else.
`default_nettype none

module hsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/hsc_core.sv */
// Heap sort sequencer: loads the set into the heap memory, builds the max-heap,
// drains it in place and reads the sorted set out. It uses hsc_pkg and hsc_ram.
`default_nettype none

module hsc_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic signed [hsc_pkg::VAL_W-1:0]  value_i,
  input  wire logic                              is_last_i,
  output logic                                   in_stall_o,
  input  wire logic                              res_taken_i,
  output hsc_pkg::res_t                          res_o
);

  import hsc_pkg::*;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [CNT_W-1:0]         lim_q, lim_d;
  logic [CNT_W-1:0]         par_q, par_d;
  logic [IDX_W-1:0]         h_q, h_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     building_q, building_d;
  logic signed [VAL_W-1:0]  held_q, held_d;
  logic signed [VAL_W-1:0]  cval_q, cval_d;
  logic signed [VAL_W-1:0]  tmp_q, tmp_d;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [VAL_W-1:0]         wdata;
  logic [IDX_W-1:0]         raddr;
  logic [VAL_W-1:0]         rdata;
  logic signed [VAL_W-1:0]  rdata_s;

  logic [CHILD_W-1:0]       child;
  logic [CHILD_W-1:0]       child_r;
  logic [CHILD_W-1:0]       lim_ext;
  logic [CNT_W-1:0]         n_inc;
  logic signed [VAL_W-1:0]  chosen;
  logic [IDX_W-1:0]         chosen_idx;
  logic                     eval;
  logic                     idx_last;

  hsc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rdata_s  = signed'(rdata);
  assign child    = {1'b0, h_q, 1'b1};
  assign child_r  = child + CHILD_W'(1);
  assign lim_ext  = CHILD_W'(lim_q);
  assign n_inc    = n_q + CNT_W'(1);
  assign idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      n_q        <= '0;
      lim_q      <= '0;
      par_q      <= '0;
      h_q        <= '0;
      idx_q      <= '0;
      step_q     <= '0;
      building_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      lim_q      <= lim_d;
      par_q      <= par_d;
      h_q        <= h_d;
      idx_q      <= idx_d;
      step_q     <= step_d;
      building_q <= building_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    cval_q <= cval_d;
    tmp_q  <= tmp_d;
  end

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    lim_d      = lim_q;
    par_d      = par_q;
    h_d        = h_q;
    idx_d      = idx_q;
    step_d     = step_q;
    building_d = building_q;
    held_d     = held_q;
    cval_d     = cval_q;
    tmp_d      = tmp_q;
    we         = 1'b0;
    waddr      = h_q;
    wdata      = held_q;
    raddr      = child[IDX_W-1:0];
    in_stall_o = 1'b1;
    chosen     = rdata_s;
    chosen_idx = child[IDX_W-1:0];
    eval       = 1'b0;
    res_o      = '{load: 1'b0, last: idx_last, value: rdata_s, count: step_q};

    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (n_q < CNT_W'(MAX_ELEMENTS)) begin
            we    = 1'b1;
            waddr = n_q[IDX_W-1:0];
            wdata = value_i;
            n_d   = n_inc;
          end
          if (is_last_i) begin
            lim_d      = n_d;
            par_d      = n_d >> 1;
            step_d     = '0;
            building_d = 1'b1;
            state_d    = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        if (par_q == '0) begin
          building_d = 1'b0;
          lim_d      = n_q;
          state_d    = ST_DRAIN;
        end else begin
          h_d     = IDX_W'(par_q - CNT_W'(1));
          raddr   = IDX_W'(par_q - CNT_W'(1));
          par_d   = par_q - CNT_W'(1);
          state_d = ST_SIFT_HELD;
        end
      end
      ST_SIFT_HELD: begin
        held_d  = rdata_s;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (child >= lim_ext) begin
          we      = 1'b1;
          state_d = building_q ? ST_BUILD : ST_DRAIN;
        end else begin
          state_d = ST_C1;
        end
      end
      ST_C1: begin
        cval_d = rdata_s;
        if (child_r < lim_ext) begin
          raddr   = child_r[IDX_W-1:0];
          state_d = ST_C2;
        end else begin
          eval = 1'b1;
        end
      end
      ST_C2: begin
        eval = 1'b1;
        if (cval_q < rdata_s) begin
          chosen     = rdata_s;
          chosen_idx = child_r[IDX_W-1:0];
        end else begin
          chosen     = cval_q;
          chosen_idx = child[IDX_W-1:0];
        end
      end
      ST_DRAIN: begin
        raddr = '0;
        if (lim_q <= CNT_W'(1)) begin
          idx_d   = '0;
          state_d = ST_OUT_LD;
        end else begin
          state_d = ST_SW_RD1;
        end
      end
      ST_SW_RD1: begin
        tmp_d   = rdata_s;
        raddr   = IDX_W'(lim_q - CNT_W'(1));
        state_d = ST_SW_WR;
      end
      ST_SW_WR: begin
        we      = 1'b1;
        waddr   = IDX_W'(lim_q - CNT_W'(1));
        wdata   = tmp_q;
        held_d  = rdata_s;
        h_d     = '0;
        lim_d   = lim_q - CNT_W'(1);
        state_d = ST_LOOP;
      end
      ST_OUT_LD: begin
        res_o.load = 1'b1;
        state_d    = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        raddr = idx_q + IDX_W'(1);
        if (res_taken_i) begin
          if (idx_last) begin
            n_d     = '0;
            step_d  = '0;
            lim_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_OUT_LD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (eval) begin
      if (step_q != '1) begin
        step_d = step_q + STEP_W'(1);
      end
      we = 1'b1;
      if (!(held_q < chosen)) begin
        state_d = building_q ? ST_BUILD : ST_DRAIN;
      end else begin
        wdata   = chosen;
        h_d     = chosen_idx;
        state_d = ST_LOOP;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/heap_sort_counted.sv */
// Counted heap sort, top level: the sort sequencer and the result output
// register. It uses hsc_pkg and hsc_core.
//
// Usage. Input beats carry value_i and is_last_i; a beat is taken when
// in_valid_i is high and in_stall_o is low. Up to 64 values are stored per
// set, one a cycle; further values are dropped, and the beat with is_last_i
// set closes the set whether stored or not. While the set is sorted and read
// out, in_stall_o stays high.
// Sorting runs on the single heap memory, with one write and one read port:
// a sift step reads one or both children and moves the larger one up while
// it beats the held value, and each drained root is swapped with the last.
// Results leave in ascending order on sorted_value_o with comparison_count_o
// (the sift steps of the whole set, saturating at 4095) and last_out_o on the
// final beat; the first result appears after the sort, and the next is read
// out once the current one is taken. A stalled result is held unchanged in the
// output register. Reset empties the set, clears the count and drops any
// pending result; the heap memory keeps its contents.
`default_nettype none

module heap_sort_counted (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [hsc_pkg::VAL_W-1:0]  value_i,
  input  wire logic                              is_last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [hsc_pkg::VAL_W-1:0]       sorted_value_o,
  output logic        [hsc_pkg::STEP_W-1:0]      comparison_count_o,
  output logic                                   last_out_o
);

  import hsc_pkg::*;

  res_t                     res;
  logic                     out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]  value_q;
  logic [STEP_W-1:0]        count_q;
  logic                     last_q;
  logic                     taken;

  hsc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .value_i     (value_i),
    .is_last_i   (is_last_i),
    .in_stall_o  (in_stall_o),
    .res_taken_i (taken),
    .res_o       (res)
  );

  assign taken = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (taken) begin
      out_valid_d = 1'b0;
    end
    if (res.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      value_q <= res.value;
      count_q <= res.count;
      last_q  <= res.last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sorted_value_o     = value_q;
  assign comparison_count_o = count_q;
  assign last_out_o         = last_q;

endmodule

`default_nettype wire
